// ===== hdl/kpwsc_pkg.sv =====
// kpwsc_pkg: constants and helper functions for the keyed packet word-sum checksum
// holds key field positions, register codes, byte swap and the keyed round
// used by: keyed_packet_word_sum_checksum_unit
`timescale 1ns / 1ps

package kpwsc_pkg;

    // register map
    localparam int unsigned AddrW          = 3;
    localparam logic        RegSessionKey  = 1'b0;

    // key field layout
    localparam int unsigned RoundLsb       = 24;
    localparam logic [2:0]  RoundMask      = 3'b111;
    localparam int unsigned ShiftLsb       = 16;
    localparam logic [3:0]  ShiftMask      = 4'b1111;
    localparam logic [3:0]  MinRounds      = 4'd2;
    localparam logic [4:0]  MinShift       = 5'd4;

    // rounds split across the two finishing stages
    localparam int unsigned StageARounds   = 5;
    localparam int unsigned MaxRounds      = 9;

    typedef logic [31:0] t_word;

    // byte-reversed word
    function automatic t_word bswap32(input t_word v);
        bswap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // round count from key bits 26:24, range 2..9
    function automatic logic [3:0] key_rounds(input t_word key);
        key_rounds = {1'b0, key[RoundLsb +: 3] & RoundMask} + MinRounds;
    endfunction

    // shift amount from key bits 19:16, range 4..19
    function automatic logic [4:0] key_shift(input t_word key);
        key_shift = {1'b0, key[ShiftLsb +: 4] & ShiftMask} + MinShift;
    endfunction

    // one keyed round: or of two opposite shifts, then xor mask
    function automatic t_word key_round(input t_word h, input logic [4:0] s,
                                        input t_word mask);
        key_round = ((h >> s) | (h << s)) ^ mask;
    endfunction

endpackage

// ===== hdl/keyed_packet_word_sum_checksum_unit.sv =====
// keyed_packet_word_sum_checksum_unit: byte-serial big-endian word sum with keyed finish
// depends on: kpwsc_pkg (key fields, byte swap, round function)
// channel      | direction | handshake          | payload
// byte in      | input     | i_valid / o_stall  | i_data_byte, i_last_byte
// checksum out | output    | o_valid / i_stall  | o_checksum
// config       | input     | apb psel/penable   | session_key at byte address 0
//
// one byte per cycle unless o_stall; the sum register adds it in the same cycle
// a last byte launches the finish through two round stages and an output register,
// so its checksum passes stage a, stage b and the output register in that order
// rounds 1..5 run in the first finish stage, rounds 6..9 and the byte swap in the second
// synchronous active-low reset clears the sum, the lane and all stage valids
// a stalled output backs up the finish stages; input stalls only when they are all full
`timescale 1ns / 1ps

module keyed_packet_word_sum_checksum_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    // checksum output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [31:0]                    o_checksum,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kpwsc_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import kpwsc_pkg::*;

    t_word        r_session_key;
    t_word        r_sum;
    logic [1:0]   r_lane;
    logic         r_a_valid;
    t_word        r_a_sum;
    t_word        r_a_key;
    logic         r_b_valid;
    t_word        r_b_hash;
    t_word        r_b_key;
    logic         r_out_valid;
    t_word        r_out_cksum;

    logic         key_sel;
    logic         in_xfer;
    logic         cfg_wr;
    logic         out_ready;
    logic         b_ready;
    logic         a_ready;
    t_word        byte_term;
    t_word        n_sum;
    t_word        a_hash;
    t_word        b_hash;

    // configuration register
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign key_sel = (paddr[AddrW-1] == RegSessionKey);
    assign prdata  = key_sel ? r_session_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_key <= '0;
        end else if (cfg_wr && key_sel) begin
            r_session_key <= pwdata;
        end
    end

    // backpressure chain from the output register down to the input
    assign out_ready = !r_out_valid || !i_stall;
    assign b_ready   = !r_b_valid || out_ready;
    assign a_ready   = !r_a_valid || b_ready;
    assign o_stall   = !a_ready;
    assign in_xfer   = i_valid && !o_stall;

    // byte placed at its big-endian lane, added to the running sum
    assign byte_term = {i_data_byte, 24'd0} >> {r_lane, 3'b000};
    assign n_sum     = r_sum + byte_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_lane <= '0;
        end else if (in_xfer) begin
            if (i_last_byte) begin
                r_sum  <= '0;
                r_lane <= '0;
            end else begin
                r_sum  <= n_sum;
                r_lane <= r_lane + 2'd1;
            end
        end
    end

    // finish stage a capture: final sum and key at the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= in_xfer && i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && in_xfer && i_last_byte) begin
            r_a_sum <= n_sum;
            r_a_key <= r_session_key;
        end
    end

    // first group of rounds
    always_comb begin
        a_hash = r_a_sum;
        for (int i = 0; i < StageARounds; i++) begin
            if (4'(i) < key_rounds(r_a_key)) begin
                a_hash = key_round(a_hash, key_shift(r_a_key), bswap32(r_a_key));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_hash <= a_hash;
            r_b_key  <= r_a_key;
        end
    end

    // remaining rounds
    always_comb begin
        b_hash = r_b_hash;
        for (int i = StageARounds; i < MaxRounds; i++) begin
            if (4'(i) < key_rounds(r_b_key)) begin
                b_hash = key_round(b_hash, key_shift(r_b_key), bswap32(r_b_key));
            end
        end
    end

    // output register holds the byte-swapped checksum until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_b_valid) begin
            r_out_cksum <= bswap32(b_hash);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_checksum = r_out_cksum;

endmodule

// ===== tb/sv/tb_keyed_packet_word_sum_checksum_unit.sv =====
// tb_keyed_packet_word_sum_checksum_unit: self-checking bench for the keyed word-sum checksum
// drives packet bytes, session keys over apb and stalls, checks each checksum against a predictor
// depends on: kpwsc_pkg, keyed_packet_word_sum_checksum_unit
`timescale 1ns / 1ps

// predictor and scoreboard: tracks the word sum, lane and key, queues expected checksums
class checksum_scoreboard;
    logic [31:0] key_q;
    logic [31:0] word_sum;
    logic [1:0]  lane;
    logic [31:0] expected_sums[$];
    int          fail_cnt;
    int          checked_cnt;

    function new();
        key_q       = '0;
        word_sum    = '0;
        lane        = '0;
        fail_cnt    = 0;
        checked_cnt = 0;
    endfunction

    function void set_key(input logic [31:0] k);
        key_q = k;
    endfunction

    function logic [31:0] byte_reverse(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // keyed finish: or of two shifts plus xor, repeated, then byte reversed
    function logic [31:0] keyed_finish(input logic [31:0] h_in, input logic [31:0] k);
        logic [31:0] h;
        logic [31:0] xmask;
        int unsigned n_rounds;
        int unsigned sh;
        h        = h_in;
        xmask    = byte_reverse(k);
        n_rounds = k[26:24] + 2;
        sh       = k[19:16] + 4;
        for (int unsigned r = 0; r < n_rounds; r++) begin
            h = ((h >> sh) | (h << sh)) ^ xmask;
        end
        return byte_reverse(h);
    endfunction

    // accepted byte transfer: accumulate, finish on the last byte
    function void note_byte(input logic [7:0] b, input logic last);
        logic [31:0] placed;
        logic [31:0] finished;
        placed   = {24'd0, b} << (24 - 8 * lane);
        word_sum = word_sum + placed;
        lane     = lane + 2'd1;
        if (last) begin
            finished      = keyed_finish(word_sum, key_q);
            expected_sums = {expected_sums, finished};
            word_sum      = '0;
            lane          = '0;
        end
    endfunction

    function void report_fail(input logic [31:0] exp_v, input logic [31:0] act_v,
                              input bit orphan);
        if (fail_cnt < 10) begin
            if (orphan)
                $display("[%0t] checksum 0x%08h arrived with none expected", $time, act_v);
            else
                $display("[%0t] checksum mismatch: expected 0x%08h got 0x%08h",
                         $time, exp_v, act_v);
        end
        fail_cnt++;
    endfunction

    // accepted result transfer: compare with the oldest expectation
    function void check_checksum(input logic [31:0] actual);
        logic [31:0] exp_v;
        if (expected_sums.size() == 0) begin
            report_fail('0, actual, 1'b1);
        end else begin
            exp_v = expected_sums.pop_front();
            checked_cnt++;
            if (actual !== exp_v)
                report_fail(exp_v, actual, 1'b0);
        end
    endfunction

    function void check_leftover();
        if (expected_sums.size() != 0) begin
            $display("%0d expected checksums never arrived", expected_sums.size());
            fail_cnt++;
        end
    endfunction
endclass

module tb_keyed_packet_word_sum_checksum_unit;
    import kpwsc_pkg::*;

    localparam int  ClkHalf    = 2;
    localparam int  CycleLimit = 300000;
    localparam int  PhaseBytes = 208;
    localparam int  HoldCycles = 400;
    localparam int  HoldAtPkt  = 12;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    logic [7:0]          i_data_byte = '0;
    logic                i_last_byte = 1'b0;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    logic [31:0]         o_checksum;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [AddrW-1:0]    paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    checksum_scoreboard  sb = new();

    int                  cycle_cnt   = 0;
    int                  bytes_sent  = 0;
    int                  keys_used   = 0;
    int                  burst_left  = 0;
    int                  pkt_left    = 0;

    keyed_packet_word_sum_checksum_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_checksum  (o_checksum),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        forever #ClkHalf i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: checks each transfer, stalls in changing modes, one long hold-off
    int  stall_mode = 0;
    int  mode_left  = 0;
    int  hold_cnt   = 0;
    bit  hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_checksum(o_checksum);
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= 1'b1;
        end else if (!hold_done && sb.checked_cnt >= HoldAtPkt) begin
            hold_done <= 1'b1;
            hold_cnt  <= HoldCycles;
            i_stall   <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(10, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 2) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (cycle_cnt % 5 < 2);
            endcase
        end
    end

    // one byte transfer, then a random gap at the end of each burst
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, last);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop offering, let every checksum drain, then wait with the input idle
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // apb write of the session key: setup then access
    task automatic write_key(input logic [31:0] k);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(4 * RegSessionKey);
        pwdata  <= k;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_key(k);
        keys_used++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random packets; a packet may run across a key change
    task automatic run_random(input int n);
        logic [7:0] b;
        int         pick;
        for (int i = 0; i < n; i++) begin
            if (pkt_left == 0) begin
                pick     = $urandom_range(0, 19);
                pkt_left = (pick < 16) ? $urandom_range(1, 12) :
                           (pick < 19) ? $urandom_range(13, 40) : 1;
            end
            pick = $urandom_range(0, 9);
            b    = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            send_byte(b, pkt_left == 1);
            pkt_left--;
        end
    endtask

    logic [31:0] key_plan[5];

    initial begin
        key_plan[0] = 32'h000F_0000;
        key_plan[1] = 32'hFFFF_FFFF;
        key_plan[2] = $urandom;
        key_plan[3] = 32'h0000_0000;
        key_plan[4] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed, reset key: single bytes, full word, lane wrap, padded short word
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        repeat (3) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
        settle();

        // all-ones key, sum wraps past 2^32
        write_key(32'hFFFF_FFFF);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        // key changed in the middle of a packet, most rounds and smallest shift
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        settle();
        write_key(32'h0700_0000);
        send_byte(8'h56, 1'b1);

        run_random(PhaseBytes);
        for (int p = 0; p < 5; p++) begin
            settle();
            write_key(key_plan[p]);
            run_random(PhaseBytes);
        end
        if (pkt_left > 0)
            send_byte(8'($urandom), 1'b1);
        settle();
        repeat (10) @(posedge i_clk);

        sb.check_leftover();
        $display("covered %0d bytes, %0d checksums checked, %0d key writes",
                 bytes_sent, sb.checked_cnt, keys_used);
        $display("key settings included all-zero, all-ones and round/shift extremes");
        if (sb.fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d failures", sb.fail_cnt);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/kpwsc_pkg.sv
hdl/keyed_packet_word_sum_checksum_unit.sv
tb/sv/tb_keyed_packet_word_sum_checksum_unit.sv
